// ===== hdl/cidr_alm_pkg.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list match package
// Shared types, codes and the prefix mask helper for the allow-list engine.
// ----------------------------------------------------------------------------
package cidr_alm_pkg;

	localparam int unsigned ADDR_W      = 128;
	localparam int unsigned PLEN_W      = 8;
	localparam int unsigned CNT_OUT_W   = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [PLEN_W-1:0] MAX_PLEN_V4 = 8'd32;
	localparam logic [PLEN_W-1:0] MAX_PLEN_V6 = 8'd128;

	localparam logic [ADDR_W-1:0] V4_ADDR_MASK = {32'hFFFF_FFFF, 96'h0};

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK          = 2'd0,
		STATUS_PREFIX_LONG = 2'd1,
		STATUS_FULL        = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RESP
	} back_state_t;

	typedef struct packed {
		op_t               op;
		logic              is_ipv6;
		logic [ADDR_W-1:0] addr;
		logic [PLEN_W-1:0] plen;
		logic              too_long;
	} item_t;

	typedef struct packed {
		logic              is_ipv6;
		logic [ADDR_W-1:0] net;
		logic [PLEN_W-1:0] plen;
	} rule_t;

	// Ones in the top plen bits; a length of 128 or more gives all ones.
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		return ~({ADDR_W{1'b1}} >> plen);
	endfunction

endpackage

// ===== hdl/cidr_alm_ifs.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list match channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface cidr_alm_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic        is_ipv6;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic [7:0]  prefix_len;

	modport source (output valid, operation, is_ipv6, addr_high, addr_low, prefix_len,
		input ready);
	modport sink (input valid, operation, is_ipv6, addr_high, addr_low, prefix_len,
		output ready);
endinterface

interface cidr_alm_out_if;
	logic       valid;
	logic       ready;
	logic       allowed;
	logic [1:0] status;
	logic [5:0] rule_count;

	modport source (output valid, allowed, status, rule_count, input ready);
	modport sink (input valid, allowed, status, rule_count, output ready);
endinterface

// ===== hdl/cidr_allow_list_match_top.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list match engine, top level
// Stores IPv4/IPv6 subnet rules and answers allow/deny lookups against them.
// ----------------------------------------------------------------------------
// Each request beat is either an insert, which masks the address to its
// prefix and appends it to a rule table of MAX_RULES entries, or a lookup,
// which is allowed when any stored rule of the same family matches. Every
// request gives exactly one response beat carrying the lookup verdict, a
// status (ok, prefix too long, table full) and the rule count after the
// request. The back end handles one request at a time: an insert passes
// through the EXEC and RESP states, a lookup of a non-empty table through
// SWEEP between them, where the rules are read from a memory with one read
// port, one rule a cycle, and the sweep stops at the first match. A
// two-entry queue and an output register let new requests be accepted
// while a response waits.
module cidr_allow_list_match_top #(
	parameter int unsigned MAX_RULES = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	cidr_alm_in_if.sink    req,
	cidr_alm_out_if.source rsp
);

	cidr_alm_pkg::item_t push_item;
	logic                push_valid;
	logic                push_ready;
	cidr_alm_pkg::item_t pop_item;
	logic                pop_valid;
	logic                pop_ready;

	cidr_alm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.push_item  (push_item),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	cidr_alm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (push_item),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.rd_item  (pop_item),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready)
	);

	cidr_alm_back #(
		.MAX_RULES (MAX_RULES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (pop_item),
		.q_valid (pop_valid),
		.q_ready (pop_ready),
		.rsp     (rsp)
	);

endmodule

// ===== hdl/cidr_alm_ram.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cidr_alm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/cidr_alm_front.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list front end
// Accepts request beats, clears unused IPv4 bits, checks the prefix length
// and masks insert addresses to their prefix before queueing.
// ----------------------------------------------------------------------------
module cidr_alm_front (
	input  logic                clk,
	input  logic                arst_n,
	cidr_alm_in_if.sink         req,
	output cidr_alm_pkg::item_t push_item,
	output logic                push_valid,
	input  logic                push_ready
);

	logic                                    valid_s1;
	cidr_alm_pkg::item_t                     item_s1;
	cidr_alm_pkg::item_t                     item_d;
	logic [cidr_alm_pkg::ADDR_W-1:0]         addr_in;
	logic [cidr_alm_pkg::PLEN_W-1:0]         plen_max;
	logic                                    take;

	assign req.ready = !valid_s1 || push_ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		addr_in = {req.addr_high, req.addr_low};
		if (!req.is_ipv6) begin
			addr_in = addr_in & cidr_alm_pkg::V4_ADDR_MASK;
		end
		plen_max = req.is_ipv6 ? cidr_alm_pkg::MAX_PLEN_V6 : cidr_alm_pkg::MAX_PLEN_V4;

		item_d.op       = cidr_alm_pkg::op_t'(req.operation);
		item_d.is_ipv6  = req.is_ipv6;
		item_d.plen     = req.prefix_len;
		item_d.too_long = req.prefix_len > plen_max;
		item_d.addr     = addr_in;
		if (item_d.op == cidr_alm_pkg::OP_INSERT) begin
			item_d.addr = addr_in & cidr_alm_pkg::prefix_mask(req.prefix_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule

// ===== hdl/cidr_alm_queue.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list item queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module cidr_alm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  cidr_alm_pkg::item_t wr_item,
	input  logic                wr_valid,
	output logic                wr_ready,
	output cidr_alm_pkg::item_t rd_item,
	output logic                rd_valid,
	input  logic                rd_ready
);

	localparam int unsigned DEPTH = cidr_alm_pkg::QUEUE_DEPTH;
	localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	cidr_alm_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]       wptr_q;
	logic [PW-1:0]       rptr_q;
	logic [CW-1:0]       fill_q;
	logic                push;
	logic                pop;

	assign wr_ready = fill_q != CW'(DEPTH);
	assign rd_valid = fill_q != '0;
	assign rd_item  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_item;
		end
	end

endmodule

// ===== hdl/cidr_alm_back.sv =====
// ----------------------------------------------------------------------------
// CIDR allow-list back end
// Appends rules to the rule memory and sweeps it one rule a cycle for
// lookups, then holds the response beat in an output register.
// ----------------------------------------------------------------------------
module cidr_alm_back #(
	parameter int unsigned MAX_RULES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cidr_alm_pkg::item_t q_item,
	input  logic                q_valid,
	output logic                q_ready,
	cidr_alm_out_if.source      rsp
);

	localparam int unsigned AW     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int unsigned CW     = $clog2(MAX_RULES + 1);
	localparam int unsigned EW     = CW + cidr_alm_pkg::CNT_OUT_W;
	localparam int unsigned RULE_W = $bits(cidr_alm_pkg::rule_t);

	cidr_alm_pkg::back_state_t state_q;
	cidr_alm_pkg::back_state_t state_d;
	cidr_alm_pkg::item_t       item_q;
	cidr_alm_pkg::status_t     res_status_q;
	logic                      res_allowed_q;
	logic [AW-1:0]             idx_q;
	logic [CW-1:0]             count_q;

	logic                                  out_valid_q;
	logic                                  out_allowed_q;
	cidr_alm_pkg::status_t                 out_status_q;
	logic [cidr_alm_pkg::CNT_OUT_W-1:0]    out_count_q;

	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_raddr;
	logic [RULE_W-1:0]     ram_rdata;
	cidr_alm_pkg::rule_t   rule_rd;
	cidr_alm_pkg::rule_t   rule_wr;
	logic                  rule_hit;
	logic                  full;
	logic                  last;
	logic                  out_free;
	logic                  load_out;
	logic [CW-1:0]         count_next;
	logic [EW-1:0]         count_ext;

	cidr_alm_ram #(
		.WIDTH (RULE_W),
		.DEPTH (MAX_RULES)
	) u_rule_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (rule_wr),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rule_rd = cidr_alm_pkg::rule_t'(ram_rdata);
	assign rule_wr = '{is_ipv6: item_q.is_ipv6, net: item_q.addr, plen: item_q.plen};

	assign rule_hit = (rule_rd.is_ipv6 == item_q.is_ipv6) &&
		(((item_q.addr ^ rule_rd.net) & cidr_alm_pkg::prefix_mask(rule_rd.plen)) == '0);

	assign full       = count_q == CW'(MAX_RULES);
	assign last       = (CW'(idx_q) + CW'(1)) == count_q;
	assign out_free   = !out_valid_q || rsp.ready;
	assign count_next = ram_we ? count_q + CW'(1) : count_q;
	assign count_ext  = EW'(count_next);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cidr_alm_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = cidr_alm_pkg::ST_EXEC;
				end
			end
			cidr_alm_pkg::ST_EXEC: begin
				if (item_q.op == cidr_alm_pkg::OP_INSERT || count_q == '0) begin
					state_d = cidr_alm_pkg::ST_RESP;
				end else begin
					state_d = cidr_alm_pkg::ST_SWEEP;
				end
			end
			cidr_alm_pkg::ST_SWEEP: begin
				if (rule_hit || last) begin
					state_d = cidr_alm_pkg::ST_RESP;
				end
			end
			cidr_alm_pkg::ST_RESP: begin
				if (out_free) begin
					state_d = cidr_alm_pkg::ST_IDLE;
				end
			end
			default: state_d = cidr_alm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		load_out  = 1'b0;
		unique case (state_q)
			cidr_alm_pkg::ST_IDLE: begin
				q_ready = 1'b1;
			end
			cidr_alm_pkg::ST_EXEC: begin
				ram_re = (item_q.op == cidr_alm_pkg::OP_LOOKUP) && (count_q != '0);
			end
			cidr_alm_pkg::ST_SWEEP: begin
				ram_re    = !rule_hit && !last;
				ram_raddr = idx_q + AW'(1);
			end
			cidr_alm_pkg::ST_RESP: begin
				load_out = out_free;
			end
			default: begin
				q_ready = 1'b0;
			end
		endcase
	end

	assign ram_we = load_out && (item_q.op == cidr_alm_pkg::OP_INSERT) &&
		(res_status_q == cidr_alm_pkg::STATUS_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cidr_alm_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_valid && q_ready) begin
			item_q <= q_item;
		end
		if (state_q == cidr_alm_pkg::ST_EXEC) begin
			idx_q         <= '0;
			res_allowed_q <= 1'b0;
			if (item_q.op == cidr_alm_pkg::OP_INSERT && item_q.too_long) begin
				res_status_q <= cidr_alm_pkg::STATUS_PREFIX_LONG;
			end else if (item_q.op == cidr_alm_pkg::OP_INSERT && full) begin
				res_status_q <= cidr_alm_pkg::STATUS_FULL;
			end else begin
				res_status_q <= cidr_alm_pkg::STATUS_OK;
			end
		end
		if (state_q == cidr_alm_pkg::ST_SWEEP) begin
			idx_q         <= idx_q + AW'(1);
			res_allowed_q <= rule_hit;
		end
		if (load_out) begin
			out_allowed_q <= res_allowed_q;
			out_status_q  <= res_status_q;
			out_count_q   <= count_ext[cidr_alm_pkg::CNT_OUT_W-1:0];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.allowed    = out_allowed_q;
	assign rsp.status     = out_status_q;
	assign rsp.rule_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RULES))
		else $error("Rule count exceeds the table size.");

	a_sweep_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cidr_alm_pkg::ST_SWEEP |-> CW'(idx_q) < count_q)
		else $error("Sweep index reached an unwritten rule.");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !full)
		else $error("Rule written into a full table.");

	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> count_q == $past(count_q) + CW'(1))
		else $error("Rule count did not follow a rule write.");

endmodule
